FILE: design/lpg_pkg.sv
// lpg_pkg: shared constants and types of the line pixel generator
// depends on nothing; used by the interfaces, all modules and the checker

package lpg_pkg;

	// port field widths
	localparam int FIELD_BITS  = 6;
	localparam int COLOUR_BITS = 24;

	// coordinates are masked to this many low bits (range 2 to 6)
	localparam int COORD_BITS = 6;

	// signed error accumulator, holds up to three major spans
	localparam int ERR_BITS = COORD_BITS + 3;

	// command queue between front and back, power of two
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	typedef logic [COORD_BITS-1:0]  coord_t;
	typedef logic [COLOUR_BITS-1:0] colour_t;

	// one classified line, ready for stepping
	typedef struct packed {
		logic                steep;
		coord_t              maj_start;
		coord_t              maj_end;
		coord_t              min_start;
		logic                min_up;
		coord_t              span;
		logic [COORD_BITS:0] twice_minor;
		colour_t             colour;
	} lpg_cmd_t;

endpackage

FILE: design/lpg_if.sv
// lpg_if: stream interfaces for line requests and emitted pixels
// depends on lpg_pkg

interface lpg_line_if import lpg_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [FIELD_BITS-1:0]  start_x;
	logic [FIELD_BITS-1:0]  start_y;
	logic [FIELD_BITS-1:0]  end_x;
	logic [FIELD_BITS-1:0]  end_y;
	logic [COLOUR_BITS-1:0] colour;

	modport source (output valid, start_x, start_y, end_x, end_y, colour, input ready);
	modport sink   (input valid, start_x, start_y, end_x, end_y, colour, output ready);
endinterface

interface lpg_pixel_if import lpg_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [FIELD_BITS-1:0]  pixel_x;
	logic [FIELD_BITS-1:0]  pixel_y;
	logic [COLOUR_BITS-1:0] pixel_colour;
	logic                   last_pixel;

	modport source (output valid, pixel_x, pixel_y, pixel_colour, last_pixel, input ready);
	modport sink   (input valid, pixel_x, pixel_y, pixel_colour, last_pixel, output ready);
endinterface

FILE: design/lpg_front.sv
// lpg_front: accepts line requests and classifies them into step commands
// depends on lpg_pkg and lpg_line_if

module lpg_front import lpg_pkg::*; (
	lpg_line_if.sink  line,
	output lpg_cmd_t  cmd,
	output logic      cmd_valid,
	input  logic      cmd_ready
);

	coord_t ax, ay, bx, by;
	coord_t adx, ady;
	logic   steep;
	coord_t maj_a, min_a, maj_b, min_b;
	logic   swap;
	coord_t maj_start, maj_end, min_start, min_end;
	coord_t dmin;

	// a request is taken whenever the queue has room
	assign line.ready = cmd_ready;
	assign cmd_valid  = line.valid;

	// mask coordinates and pick the major axis
	always_comb begin
		ax = line.start_x[COORD_BITS-1:0];
		ay = line.start_y[COORD_BITS-1:0];
		bx = line.end_x[COORD_BITS-1:0];
		by = line.end_y[COORD_BITS-1:0];
		adx = (ax > bx) ? ax - bx : bx - ax;
		ady = (ay > by) ? ay - by : by - ay;
		// equal spans keep x as the major axis
		steep = adx < ady;
		maj_a = steep ? ay : ax;
		min_a = steep ? ax : ay;
		maj_b = steep ? by : bx;
		min_b = steep ? bx : by;
	end

	// order the endpoints along the major axis
	always_comb begin
		swap      = maj_a > maj_b;
		maj_start = swap ? maj_b : maj_a;
		maj_end   = swap ? maj_a : maj_b;
		min_start = swap ? min_b : min_a;
		min_end   = swap ? min_a : min_b;
		dmin      = (min_end > min_start) ? min_end - min_start : min_start - min_end;
	end

	// build the command
	always_comb begin
		cmd.steep       = steep;
		cmd.maj_start   = maj_start;
		cmd.maj_end     = maj_end;
		cmd.min_start   = min_start;
		cmd.min_up      = min_end > min_start;
		cmd.span        = maj_end - maj_start;
		cmd.twice_minor = {dmin, 1'b0};
		cmd.colour      = line.colour;
	end

endmodule

FILE: design/lpg_queue.sv
// lpg_queue: short command queue between front and back
// depends on lpg_pkg

module lpg_queue import lpg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  lpg_cmd_t push_cmd,
	input  logic     push_valid,
	output logic     push_ready,
	output lpg_cmd_t pop_cmd,
	output logic     pop_valid,
	input  logic     pop_ready
);

	lpg_cmd_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;
	logic                 push;
	logic                 pop;

	assign push_ready = count_q != (QPTR_BITS+1)'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

FILE: design/lpg_back.sv
// lpg_back: steps the major axis one pixel a cycle unless the pixel port stalls; drives that port
// depends on lpg_pkg and lpg_pixel_if

module lpg_back import lpg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  lpg_cmd_t  cmd,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	lpg_pixel_if.source pixel
);

	lpg_cmd_t             cmd_q;
	logic                 busy_q;
	coord_t               maj_q;
	coord_t               min_q;
	logic signed [ERR_BITS-1:0] err_q;

	logic                 out_valid_q;
	coord_t               out_x_q;
	coord_t               out_y_q;
	colour_t              out_colour_q;
	logic                 out_last_q;

	logic                 advance;
	logic                 is_last;
	logic signed [ERR_BITS-1:0] err_sum;
	logic                 min_move;

	assign cmd_ready = !busy_q;
	assign advance   = busy_q && (!out_valid_q || pixel.ready);
	assign is_last   = maj_q == cmd_q.maj_end;

	// error accumulator step
	always_comb begin
		err_sum  = err_q + $signed(ERR_BITS'(cmd_q.twice_minor));
		min_move = err_sum > $signed(ERR_BITS'(cmd_q.span));
	end

	// line control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (!busy_q) begin
			busy_q <= cmd_valid;
		end else if (advance && is_last) begin
			busy_q <= 1'b0;
		end
	end

	// stepping registers
	always_ff @(posedge clk) begin
		if (!busy_q) begin
			cmd_q <= cmd;
			maj_q <= cmd.maj_start;
			min_q <= cmd.min_start;
			err_q <= '0;
		end else if (advance) begin
			maj_q <= maj_q + 1'b1;
			if (min_move) begin
				min_q <= cmd_q.min_up ? min_q + 1'b1 : min_q - 1'b1;
				err_q <= err_sum - $signed(ERR_BITS'({cmd_q.span, 1'b0}));
			end else begin
				err_q <= err_sum;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (pixel.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			out_x_q      <= cmd_q.steep ? min_q : maj_q;
			out_y_q      <= cmd_q.steep ? maj_q : min_q;
			out_colour_q <= cmd_q.colour;
			out_last_q   <= is_last;
		end
	end

	assign pixel.valid        = out_valid_q;
	assign pixel.pixel_x      = FIELD_BITS'(out_x_q);
	assign pixel.pixel_y      = FIELD_BITS'(out_y_q);
	assign pixel.pixel_colour = out_colour_q;
	assign pixel.last_pixel   = out_last_q;

endmodule

FILE: design/line_pixel_generator.sv
// line_pixel_generator: line rasteriser top level, front, queue and back
// depends on lpg_pkg, lpg_if, lpg_front, lpg_queue, lpg_back
//
// channel | role | payload                                        | request
// --------+------+------------------------------------------------+----------------
// line    | sink | start_x, start_y, end_x, end_y, colour         | one line
// pixel   | src  | pixel_x, pixel_y, pixel_colour, last_pixel     | one pixel
//
// a line of major span n gives n+1 pixel requests, one a cycle unless the pixel
// port stalls; the stepping unit in lpg_back loads each command while idle
// the front classifies a line in the cycle it is taken and the queue holds two
// lines ahead of the back
// reset is asynchronous, active low, and empties queue and output register
// a stall on the pixel port holds the stepping unit; the line port stalls
// only once the queue is full

module line_pixel_generator import lpg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	lpg_line_if.sink    line,
	lpg_pixel_if.source pixel
);

	lpg_cmd_t front_cmd;
	logic     front_valid;
	logic     front_ready;
	lpg_cmd_t back_cmd;
	logic     back_valid;
	logic     back_ready;

	// classify incoming lines
	lpg_front u_front (
		.line      (line),
		.cmd       (front_cmd),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready)
	);

	// decouple front and back
	lpg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cmd   (front_cmd),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_cmd    (back_cmd),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready)
	);

	// step and emit pixels
	lpg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (back_cmd),
		.cmd_valid (back_valid),
		.cmd_ready (back_ready),
		.pixel     (pixel)
	);

endmodule

FILE: design/lpg_checker.sv
// lpg_checker: port-level checks of the line pixel generator, bound to the top
// depends on lpg_pkg

module lpg_checker import lpg_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   line_valid,
	input logic                   line_ready,
	input logic                   pixel_valid,
	input logic                   pixel_ready,
	input logic [FIELD_BITS-1:0]  pixel_x,
	input logic [FIELD_BITS-1:0]  pixel_y,
	input logic [COLOUR_BITS-1:0] pixel_colour,
	input logic                   last_pixel
);

	localparam int MAX_LINES = QUEUE_DEPTH + 2;

	logic [2:0]             pending_q;
	logic                   have_prev_q;
	logic                   prev_last_q;
	logic [FIELD_BITS-1:0]  prev_x_q;
	logic [FIELD_BITS-1:0]  prev_y_q;
	logic [COLOUR_BITS-1:0] prev_colour_q;
	logic                   line_take;
	logic                   pixel_take;
	logic                   near_x;
	logic                   near_y;

	assign line_take  = line_valid && line_ready;
	assign pixel_take = pixel_valid && pixel_ready;

	// lines taken whose last pixel has not gone out yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (line_take && !(pixel_take && last_pixel)) begin
			pending_q <= pending_q + 1'b1;
		end else if (!line_take && pixel_take && last_pixel) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	// previous pixel taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
		end else if (pixel_take) begin
			have_prev_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pixel_take) begin
			prev_last_q   <= last_pixel;
			prev_x_q      <= pixel_x;
			prev_y_q      <= pixel_y;
			prev_colour_q <= pixel_colour;
		end
	end

	// neighbouring pixel test
	always_comb begin
		near_x = (pixel_x == prev_x_q) || (pixel_x == prev_x_q + 1'b1) ||
			(pixel_x == prev_x_q - 1'b1);
		near_y = (pixel_y == prev_y_q) || (pixel_y == prev_y_q + 1'b1) ||
			(pixel_y == prev_y_q - 1'b1);
	end

	// a stalled pixel request holds
	a_pixel_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && !pixel_ready |=> pixel_valid && $stable(pixel_x) &&
			$stable(pixel_y) && $stable(pixel_colour) && $stable(last_pixel))
		else $error("pixel request changed while stalled");

	// no pixel without a line in flight
	a_pixel_owned: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid |-> pending_q != '0)
		else $error("pixel with no line outstanding");

	// lines in flight stay within queue, stepper and output register
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'(MAX_LINES))
		else $error("too many lines in flight");

	// pixels inside one line are neighbours in the same colour
	a_line_connected: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && have_prev_q && !prev_last_q |->
			near_x && near_y && pixel_colour == prev_colour_q)
		else $error("line broken between consecutive pixels");

endmodule

bind line_pixel_generator lpg_checker u_lpg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.line_valid   (line.valid),
	.line_ready   (line.ready),
	.pixel_valid  (pixel.valid),
	.pixel_ready  (pixel.ready),
	.pixel_x      (pixel.pixel_x),
	.pixel_y      (pixel.pixel_y),
	.pixel_colour (pixel.pixel_colour),
	.last_pixel   (pixel.last_pixel)
);

FILE: dv/lpg_pixel_checker.sv
// lpg_pixel_checker: watches the line and pixel channels of the line pixel generator,
// rasterises every accepted line itself and compares each emitted pixel in order
// depends on lpg_pkg and lpg_if
`timescale 1ns / 1ps

module lpg_pixel_checker import lpg_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	lpg_line_if   line,
	lpg_pixel_if  pixel,
	output int    fail_count,
	output int    pending
);

	typedef struct packed {
		coord_t  x;
		coord_t  y;
		colour_t colour;
		logic    last;
	} pixel_t;

	pixel_t pixels_due[$];

	// bresenham walk of one line, pixels pushed in emission order
	function automatic void rasterise_line(input coord_t sx, input coord_t sy,
		input coord_t ex, input coord_t ey, input colour_t col);
		int     a_maj, a_min, b_maj, b_min, tmp;
		int     span, twice_min, err, minor, dir, maj;
		bit     steep;
		pixel_t px;
		a_maj = sx;
		a_min = sy;
		b_maj = ex;
		b_min = ey;
		steep = 1'b0;
		// swap axes when y spans further than x; equal spans stay on x
		if (((a_maj > b_maj) ? a_maj - b_maj : b_maj - a_maj) <
		    ((a_min > b_min) ? a_min - b_min : b_min - a_min)) begin
			tmp = a_maj; a_maj = a_min; a_min = tmp;
			tmp = b_maj; b_maj = b_min; b_min = tmp;
			steep = 1'b1;
		end
		// walk the major axis upwards
		if (a_maj > b_maj) begin
			tmp = a_maj; a_maj = b_maj; b_maj = tmp;
			tmp = a_min; a_min = b_min; b_min = tmp;
		end
		span      = b_maj - a_maj;
		dir       = (b_min > a_min) ? 1 : -1;
		twice_min = 2 * ((a_min > b_min) ? a_min - b_min : b_min - a_min);
		err       = 0;
		minor     = a_min;
		for (maj = a_maj; maj <= b_maj; maj++) begin
			px.x      = coord_t'(steep ? minor : maj);
			px.y      = coord_t'(steep ? maj : minor);
			px.colour = col;
			px.last   = (maj == b_maj);
			pixels_due.push_back(px);
			err += twice_min;
			if (err > span) begin
				minor += dir;
				err   -= 2 * span;
			end
		end
	endfunction

	// predict on each line request, compare on each pixel request
	always @(posedge clk or negedge arst_n) begin
		pixel_t got, want;
		if (!arst_n) begin
			pixels_due.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (line.valid && line.ready)
				rasterise_line(coord_t'(line.start_x), coord_t'(line.start_y),
					coord_t'(line.end_x), coord_t'(line.end_y), line.colour);
			if (pixel.valid && pixel.ready) begin
				got.x      = coord_t'(pixel.pixel_x);
				got.y      = coord_t'(pixel.pixel_y);
				got.colour = pixel.pixel_colour;
				got.last   = pixel.last_pixel;
				if (pixels_due.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected pixel, expected none, got x=%0d y=%0d colour=%06h last=%0b",
						$realtime, got.x, got.y, got.colour, got.last);
				end else begin
					want = pixels_due.pop_front();
					if (got !== want) begin
						fail_count++;
						$display("%0t: pixel mismatch, expected x=%0d y=%0d colour=%06h last=%0b",
							$realtime, want.x, want.y, want.colour, want.last);
						$display("%0t: pixel mismatch, actual   x=%0d y=%0d colour=%06h last=%0b",
							$realtime, got.x, got.y, got.colour, got.last);
					end
				end
			end
			pending = pixels_due.size();
		end
	end

endmodule

FILE: dv/tb_line_pixel_generator.sv
// tb_line_pixel_generator: clock, reset and stimulus for the line pixel generator
// depends on lpg_pkg, lpg_if, line_pixel_generator and lpg_pixel_checker
`timescale 1ns / 1ps

module tb_line_pixel_generator import lpg_pkg::*; ();

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_LINES = 242;
	localparam int DRAIN_CYCLES = 70;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AFTER   = 150;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycle_count;
	bit   line_calm;

	lpg_line_if  line_ch ();
	lpg_pixel_if pixel_ch ();

	line_pixel_generator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.line   (line_ch),
		.pixel  (pixel_ch)
	);

	lpg_pixel_checker pixel_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.line       (line_ch),
		.pixel      (pixel_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// offer one line request after a random gap, return once it is taken
	task automatic offer_line(input coord_t sx, input coord_t sy, input coord_t ex,
		input coord_t ey, input colour_t col);
		int gap;
		gap = line_calm ? 0 : $urandom_range(0, 11);
		@(negedge clk);
		if (gap > 0) begin
			line_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		line_ch.valid   = 1'b1;
		line_ch.start_x = sx;
		line_ch.start_y = sy;
		line_ch.end_x   = ex;
		line_ch.end_y   = ey;
		line_ch.colour  = col;
		do @(posedge clk); while (!line_ch.ready);
		if ($urandom_range(0, 39) == 0)
			line_calm = !line_calm;
	endtask

	// pixel receiver: random stalls, calm stretches and one long hold-off
	initial begin
		int stall;
		int taken;
		bit held;
		bit calm;
		pixel_ch.ready = 1'b0;
		taken = 0;
		held  = 1'b0;
		calm  = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 11);
			// hold off long enough for the queue to fill and stall the line port
			if (!held && taken >= HOLD_AFTER) begin
				stall = HOLD_CYCLES;
				held  = 1'b1;
			end
			@(negedge clk);
			if (stall > 0) begin
				pixel_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			pixel_ch.ready = 1'b1;
			do @(posedge clk); while (!pixel_ch.valid);
			taken++;
			if ($urandom_range(0, 39) == 0)
				calm = !calm;
		end
	end

	// reset, stimulus and verdict
	initial begin
		int     kind;
		coord_t sx, sy, ex, ey;
		arst_n          = 1'b0;
		line_calm       = 1'b0;
		line_ch.valid   = 1'b0;
		line_ch.start_x = '0;
		line_ch.start_y = '0;
		line_ch.end_x   = '0;
		line_ch.end_y   = '0;
		line_ch.colour  = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// single points at both corners
		offer_line(0, 0, 0, 0, 24'h000000);
		offer_line(63, 63, 63, 63, 24'hffffff);
		// full-length horizontal and vertical, both directions
		offer_line(0, 0, 63, 0, 24'haaaaaa);
		offer_line(63, 5, 0, 5, 24'h555555);
		offer_line(7, 0, 7, 63, 24'h123456);
		offer_line(9, 63, 9, 0, 24'hfedcba);
		// equal spans in every direction, x stays major
		offer_line(0, 0, 63, 63, 24'hff0000);
		offer_line(63, 63, 0, 0, 24'h00ff00);
		offer_line(0, 63, 63, 0, 24'h0000ff);
		offer_line(63, 0, 0, 63, 24'h808080);
		// shallow and steep, rising and falling, reversed endpoints
		offer_line(10, 3, 50, 20, 24'h0f0f0f);
		offer_line(50, 20, 10, 3, 24'hf0f0f0);
		offer_line(10, 40, 55, 30, 24'h3c3c3c);
		offer_line(3, 10, 20, 50, 24'hc3c3c3);
		offer_line(20, 50, 3, 10, 24'h010203);
		offer_line(40, 10, 30, 55, 24'h7f7f7f);
		// very short lines
		offer_line(5, 5, 6, 7, 24'h999999);
		offer_line(33, 21, 34, 21, 24'h666666);

		// random lines: mostly free, some short, some on the axes or diagonals
		for (int i = 0; i < RANDOM_LINES; i++) begin
			kind = $urandom_range(0, 9);
			sx   = coord_t'($urandom_range(0, 63));
			sy   = coord_t'($urandom_range(0, 63));
			ex   = coord_t'($urandom_range(0, 63));
			ey   = coord_t'($urandom_range(0, 63));
			if (kind < 2) begin
				ex = (sx > 59) ? sx - coord_t'($urandom_range(0, 3)) :
					sx + coord_t'($urandom_range(0, 3));
				ey = (sy > 59) ? sy - coord_t'($urandom_range(0, 3)) :
					sy + coord_t'($urandom_range(0, 3));
			end else if (kind == 2) begin
				if ($urandom_range(0, 1))
					ey = sy;
				else
					ex = sx;
			end else if (kind == 3) begin
				ey = (sy >= ((sx > ex) ? sx - ex : ex - sx)) ?
					sy - ((sx > ex) ? sx - ex : ex - sx) :
					sy + ((sx > ex) ? sx - ex : ex - sx);
			end
			offer_line(sx, sy, ex, ey, colour_t'($urandom()));
		end

		@(negedge clk);
		line_ch.valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: filelist.f
design/lpg_pkg.sv
design/lpg_if.sv
design/lpg_front.sv
design/lpg_queue.sv
design/lpg_back.sv
design/line_pixel_generator.sv
design/lpg_checker.sv
dv/lpg_pixel_checker.sv
dv/tb_line_pixel_generator.sv
